// ----- rtl/sld_pkg.sv -----
// package for the sync/length packet deframer
// phase and result kind codes, register indexes, reset values, length limits, result struct
// no dependencies
package sld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BODY  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TAIL  = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BODY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END_OK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_BAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LEN_ERR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hE3;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [BYTE_W-1:0] MIN_LENGTH      = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD    = 8'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_length;
    } sld_result_t;

endpackage

// ----- rtl/sync_length_packet_deframer_top.sv -----
// path: the byte is held in the input register, then its result is taken into the
// result register when the output is free
// throughput: one byte per cycle while no result waits on a stalled output; bytes
// that give no result pass even while the output register holds an untaken result
// reset: asynchronous, active low; parser returns to hunting, sync values to E3/5A
// top level: input register, sld_parser, result register; depends on sld_pkg
module sync_length_packet_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_length
);
    import sld_pkg::*;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg;
    sld_result_t       out_reg;
    logic              out_free;
    logic              step;
    logic              res_valid;
    sld_result_t       res;

    sld_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .byte_in   (s1_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // a byte with no result never waits for the output register
    assign step     = s1_valid_reg && (!res_valid || out_free);
    assign in_stall = s1_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign data_byte    = out_reg.data_byte;
    assign byte_index   = out_reg.byte_index;
    assign frame_length = out_reg.frame_length;

endmodule

// ----- rtl/sld_parser.sv -----
// frame parser state machine and sync configuration registers
// one byte per step, result decided combinationally from the current phase
// depends on sld_pkg
module sld_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sld_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        step,
    input  logic [sld_pkg::BYTE_W-1:0]  byte_in,
    output logic                        res_valid,
    output sld_pkg::sld_result_t        res
);
    import sld_pkg::*;

    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  saved_length_reg, saved_length_next;
    logic [BYTE_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]  body_position_reg, body_position_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data;
            end
            else if (cfg_index == REG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        saved_length_next  = saved_length_reg;
        bytes_left_next    = bytes_left_reg;
        body_position_next = body_position_reg;
        res_valid          = 1'b0;
        res                = '0;
        unique case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (byte_in == sync_second_reg) ? PH_LEN : PH_HUNT;
            end
            PH_LEN:
            begin
                if (byte_in < MIN_LENGTH)
                begin
                    phase_next       = PH_HUNT;
                    res_valid        = 1'b1;
                    res.kind         = KIND_LEN_ERR;
                    res.data_byte    = byte_in;
                    res.frame_length = byte_in;
                end
                else
                begin
                    saved_length_next  = byte_in;
                    bytes_left_next    = byte_in - LEN_OVERHEAD;
                    body_position_next = '0;
                    phase_next         = PH_BODY;
                end
            end
            PH_BODY:
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_BODY;
                res.data_byte      = byte_in;
                res.byte_index     = body_position_reg;
                res.frame_length   = saved_length_reg;
                body_position_next = body_position_reg + 8'd1;
                bytes_left_next    = bytes_left_reg - 8'd1;
                if (bytes_left_next == '0)
                begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                phase_next       = PH_HUNT;
                res_valid        = 1'b1;
                res.kind         = (byte_in == saved_length_reg) ? KIND_END_OK : KIND_END_BAD;
                res.data_byte    = byte_in;
                res.frame_length = saved_length_reg;
            end
            default:
            begin
                // unused codes hunt as well
                phase_next = (byte_in == sync_first_reg) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            saved_length_reg  <= '0;
            bytes_left_reg    <= '0;
            body_position_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            saved_length_reg  <= saved_length_next;
            bytes_left_reg    <= bytes_left_next;
            body_position_reg <= body_position_next;
        end
    end

endmodule

// ----- rtl/sld_checker.sv -----
// port-level checks for the deframer: output hold and result consistency
// bound to sync_length_packet_deframer_top; depends on sld_pkg
module sld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic [7:0] frame_length
);
    import sld_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(byte_index) && $stable(frame_length))
        else $error("stalled result changed");

    // body index stays inside the body of a frame of at least three
    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BODY
            |-> ({1'b0, byte_index} + 9'd3) <= {1'b0, frame_length})
        else $error("body index beyond frame length");

    a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_LEN_ERR
            |-> frame_length < MIN_LENGTH && data_byte == frame_length && byte_index == '0)
        else $error("bad length error result");

    // tail flag agrees with the tail byte
    a_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_END_OK || kind == KIND_END_BAD)
            |-> byte_index == '0 && frame_length >= MIN_LENGTH
                && ((data_byte == frame_length) == (kind == KIND_END_OK)))
        else $error("end of packet flag wrong");

endmodule

bind sync_length_packet_deframer_top sld_checker u_sld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length)
);
